>>> src/tvnh_pkg.sv
// Shared constants and arithmetic helpers for the terrain height core.
package tvnh_pkg;

    localparam logic [31:0] OCT4_OFS_X = 32'd45365;
    localparam logic [31:0] OCT4_OFS_Y = 32'd91923;
    localparam logic [31:0] OCT2_OFS_X = 32'd10294;
    localparam logic [31:0] OCT2_OFS_Y = 32'd37821;

    localparam logic [31:0] HASH_MUL   = 32'd15731;
    localparam logic [31:0] HASH_ADD   = 32'd789221;
    localparam logic [31:0] HASH_FINAL = 32'd1376312589;

    localparam logic [9:0]  HEIGHT_BIAS = 10'd35;
    localparam logic [12:0] RECIP_TENTH = 13'd6554;
    localparam logic [5:0]  HEIGHT_MIN  = 6'd10;
    localparam logic [5:0]  HEIGHT_MAX  = 6'd60;

    localparam logic [16:0] WEIGHT_ONE = 17'd65536;

    typedef logic [8:0][7:0] window_t;

    // Weight of the far corner for each eighth-turn phase of the cosine.
    function automatic logic [16:0] tvnh_weight_b(input logic [1:0] t);
        logic [16:0] w;
        unique case (t)
            2'd0: w = 17'd0;
            2'd1: w = 17'd9598;
            2'd2: w = 17'd32768;
            2'd3: w = 17'd55938;
            default: w = 17'd0;
        endcase
        return w;
    endfunction

    // Cosine blend of two non-negative lattice values.
    function automatic logic [7:0] tvnh_blend(input logic [7:0] a, input logic [7:0] b,
                                              input logic [1:0] t);
        logic [16:0] wb;
        logic [16:0] wa;
        logic [24:0] pb;
        logic [24:0] pa;
        logic [8:0]  s;
        wb = tvnh_weight_b(t);
        wa = WEIGHT_ONE - wb;
        pb = wb * {17'd0, b};
        pa = wa * {17'd0, a};
        s  = {1'b0, pb[23:16]} + {1'b0, pa[23:16]};
        return s[7:0];
    endfunction

    // Center/4 + sides/8 + corners/16 over a 3x3 window, row-major.
    function automatic logic [7:0] tvnh_smooth(input window_t w);
        logic [9:0] corners;
        logic [9:0] sides;
        logic [7:0] s;
        corners = {2'd0, w[0]} + {2'd0, w[2]} + {2'd0, w[6]} + {2'd0, w[8]};
        sides   = {2'd0, w[1]} + {2'd0, w[3]} + {2'd0, w[5]} + {2'd0, w[7]};
        s = {2'd0, w[4][7:2]} + {1'b0, sides[9:3]} + {2'd0, corners[9:4]};
        return s;
    endfunction

    // Lattice cell: coordinate over 2^k, truncated toward zero.
    function automatic logic [31:0] tvnh_cell(input logic [31:0] v, input logic [1:0] k);
        logic [31:0] sh;
        logic [31:0] mask;
        logic        adj;
        sh   = $signed(v) >>> k;
        mask = ~(32'hffff_ffff << k);
        adj  = v[31] && ((v & mask) != 32'd0);
        return sh + {31'd0, adj};
    endfunction

endpackage

>>> src/tvnh_hash.sv
// Pipelined integer lattice hash for one lattice point.
module tvnh_hash
    import tvnh_pkg::*;
#(
    parameter int OFS = 0
)
(
    input  logic        clk,
    input  logic [3:0]  en,
    input  logic [31:0] base,
    output logic [7:0]  lat
);

    logic [31:0] n3_reg;
    logic [31:0] n4_reg;
    logic [31:0] sq_reg;
    logic [31:0] n5_reg;
    logic [31:0] inner_reg;
    logic [7:0]  lat_reg;

    logic [31:0] m;
    logic [31:0] sq_next;
    logic [31:0] inner_next;
    logic [31:0] h;

    assign m          = base + 32'(OFS);
    assign sq_next    = n3_reg * n3_reg;
    assign inner_next = sq_reg * HASH_MUL + HASH_ADD;
    assign h          = n5_reg * inner_reg + HASH_FINAL;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            n3_reg <= (m << 13) ^ m;
        end
        if (en[1])
        begin
            sq_reg <= sq_next;
            n4_reg <= n3_reg;
        end
        if (en[2])
        begin
            inner_reg <= inner_next;
            n5_reg    <= n4_reg;
        end
        if (en[3])
        begin
            lat_reg <= h[26:19];
        end
    end

    assign lat = lat_reg;

endmodule

>>> src/terrain_value_noise_height_core.sv
// Top level of the three-octave value-noise terrain height core.
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+-----------------
//  coord    | coord_valid  | coord_stall  | coord_x, coord_y
//  height   | height_valid | height_stall | height
//
// Eleven register stages; one word enters per cycle while coord_stall is low.
// The three 32x32 multipliers of each lattice hash set the stage depth.
// Reset clears the stage valid bits only; no warm-up after reset.
// A stage holds only while it is full and the one after it holds, so a
// stall on height fills bubbles before coord_stall rises.
module terrain_value_noise_height_core
    import tvnh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        coord_valid,
    output logic        coord_stall,
    input  logic [31:0] coord_x,
    input  logic [31:0] coord_y,
    output logic        height_valid,
    input  logic        height_stall,
    output logic [5:0]  height
);

    logic [11:1] v_reg;
    logic [11:1] v_next;
    logic [12:1] rdy;

    assign rdy[12] = !height_stall;
    for (genvar k = 1; k <= 11; k++)
    begin : g_rdy
        assign rdy[k] = !v_reg[k] || rdy[k + 1];
    end

    always_comb
    begin
        v_next[1] = rdy[1] ? coord_valid : v_reg[1];
        for (int k = 2; k <= 11; k++)
        begin
            v_next[k] = rdy[k] ? v_reg[k - 1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // Stage 1: offsets, lattice cells and fractions.
    logic [31:0] x4, y4, x2, y2;
    logic [2:0][31:0] ix_reg, iy_reg;
    logic [8:1][5:0] frac_reg;

    assign x4 = coord_x + OCT4_OFS_X;
    assign y4 = coord_y + OCT4_OFS_Y;
    assign x2 = coord_x + OCT2_OFS_X;
    assign y2 = coord_y + OCT2_OFS_Y;

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            ix_reg[0]   <= tvnh_cell(x4, 2'd2);
            iy_reg[0]   <= tvnh_cell(y4, 2'd2);
            ix_reg[1]   <= tvnh_cell(x2, 2'd1);
            iy_reg[1]   <= tvnh_cell(y2, 2'd1);
            ix_reg[2]   <= coord_x;
            iy_reg[2]   <= coord_y;
            frac_reg[1] <= {x4[1:0], y4[1:0], x2[0], y2[0]};
        end
        for (int k = 2; k <= 8; k++)
        begin
            if (rdy[k])
            begin
                frac_reg[k] <= frac_reg[k - 1];
            end
        end
    end

    // Stage 2: row-major lattice base y*57 + x.
    logic [2:0][31:0] base_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            for (int o = 0; o < 3; o++)
            begin
                base_reg[o] <= (iy_reg[o] << 6) - (iy_reg[o] << 3) + iy_reg[o] + ix_reg[o];
            end
        end
    end

    // Stages 3 to 6: lattice hashes.
    logic [1:0][3:0][3:0][7:0] lat_a;
    logic [2:0][2:0][7:0]      lat_1;

    for (genvar o = 0; o < 2; o++)
    begin : g_oct
        for (genvar j = 0; j < 4; j++)
        begin : g_row
            for (genvar i = 0; i < 4; i++)
            begin : g_col
                tvnh_hash #(.OFS((j - 1) * 57 + (i - 1))) u_hash (
                    .clk  (clk),
                    .en   (rdy[6:3]),
                    .base (base_reg[o]),
                    .lat  (lat_a[o][j][i])
                );
            end
        end
    end

    for (genvar j = 0; j < 3; j++)
    begin : g_row1
        for (genvar i = 0; i < 3; i++)
        begin : g_col1
            tvnh_hash #(.OFS((j - 1) * 57 + (i - 1))) u_hash (
                .clk  (clk),
                .en   (rdy[6:3]),
                .base (base_reg[2]),
                .lat  (lat_1[j][i])
            );
        end
    end

    // Stage 7: 3x3 smoothing at each cell corner, and at the finest octave's own point.
    logic [1:0][1:0][1:0][7:0] sm_reg;
    logic [7:0]                sm1_reg;
    logic [1:0][1:0][1:0][7:0] sm_next;
    window_t                   w1;

    always_comb
    begin
        for (int o = 0; o < 2; o++)
        begin
            for (int cy = 0; cy < 2; cy++)
            begin
                for (int cx = 0; cx < 2; cx++)
                begin
                    sm_next[o][cy][cx] = tvnh_smooth({lat_a[o][cy + 2][cx + 2],
                        lat_a[o][cy + 2][cx + 1], lat_a[o][cy + 2][cx],
                        lat_a[o][cy + 1][cx + 2], lat_a[o][cy + 1][cx + 1],
                        lat_a[o][cy + 1][cx], lat_a[o][cy][cx + 2],
                        lat_a[o][cy][cx + 1], lat_a[o][cy][cx]});
                end
            end
        end
        w1 = {lat_1[2][2], lat_1[2][1], lat_1[2][0], lat_1[1][2], lat_1[1][1],
              lat_1[1][0], lat_1[0][2], lat_1[0][1], lat_1[0][0]};
    end

    always_ff @(posedge clk)
    begin
        if (rdy[7])
        begin
            sm_reg  <= sm_next;
            sm1_reg <= tvnh_smooth(w1);
        end
    end

    // Stage 8: blend along x.
    logic [1:0][1:0][7:0] rx_reg;
    logic [7:0]           sm1_d_reg;
    logic [1:0]           tx4, ty4, tx2, ty2;

    assign tx4 = frac_reg[7][5:4];
    assign tx2 = {frac_reg[7][1], 1'b0};
    assign ty4 = frac_reg[8][3:2];
    assign ty2 = {frac_reg[8][0], 1'b0};

    always_ff @(posedge clk)
    begin
        if (rdy[8])
        begin
            for (int r = 0; r < 2; r++)
            begin
                rx_reg[0][r] <= tvnh_blend(sm_reg[0][r][0], sm_reg[0][r][1], tx4);
                rx_reg[1][r] <= tvnh_blend(sm_reg[1][r][0], sm_reg[1][r][1], tx2);
            end
            sm1_d_reg <= sm1_reg;
        end
    end

    // Stage 9: blend along y.
    logic [7:0] o4_reg, o2_reg, o1_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[9])
        begin
            o4_reg <= tvnh_blend(rx_reg[0][0], rx_reg[0][1], ty4);
            o2_reg <= tvnh_blend(rx_reg[1][0], rx_reg[1][1], ty2);
            o1_reg <= sm1_d_reg;
        end
    end

    // Stage 10: octave sum, times three, split into sign and magnitude.
    logic signed [9:0]  a_s, b_s, c_s, sum_s;
    logic signed [11:0] t3_s;
    logic [9:0]         mag_reg;
    logic               neg_reg;

    always_comb
    begin
        a_s   = $signed({2'b00, o4_reg}) - 10'sd128;
        b_s   = ($signed({2'b00, o2_reg}) - 10'sd128) >>> 1;
        c_s   = ($signed({2'b00, o1_reg}) - 10'sd128) >>> 2;
        sum_s = a_s + b_s + c_s;
        t3_s  = 12'(sum_s) * 12'sd3;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[10])
        begin
            neg_reg <= t3_s[11];
            mag_reg <= t3_s[11] ? 10'(-t3_s) : t3_s[9:0];
        end
    end

    // Stage 11: divide by ten, bias, clamp.
    logic [22:0] q_prod;
    logic [9:0]  q;
    logic [9:0]  hv;
    logic        hv_neg;
    logic [5:0]  height_next;
    logic [5:0]  height_reg;

    always_comb
    begin
        q_prod = {13'd0, mag_reg} * {10'd0, RECIP_TENTH};
        q      = {3'd0, q_prod[22:16]};
        hv     = neg_reg ? HEIGHT_BIAS - q : HEIGHT_BIAS + q;
        hv_neg = neg_reg && (q > HEIGHT_BIAS);
        priority if (hv_neg || hv < {4'd0, HEIGHT_MIN})
        begin
            height_next = HEIGHT_MIN;
        end
        else if (hv > {4'd0, HEIGHT_MAX})
        begin
            height_next = HEIGHT_MAX;
        end
        else
        begin
            height_next = hv[5:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[11])
        begin
            height_reg <= height_next;
        end
    end

    assign coord_stall  = !rdy[1];
    assign height_valid = v_reg[11];
    assign height       = height_reg;

endmodule

>>> src/tvnh_checker.sv
// Port checker for the terrain height core and its bind.
module tvnh_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        coord_stall,
    input logic        height_valid,
    input logic        height_stall,
    input logic [5:0]  height
);

    a_height_range: assert property (@(posedge clk) disable iff (!rst_n)
        height_valid |-> (height >= 6'd10 && height <= 6'd60))
        else $error("height out of range");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        coord_stall |-> (height_valid && height_stall))
        else $error("coord stalled while output side moves");

    a_output_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (height_valid && height_stall) |=> (height_valid && $stable(height)))
        else $error("stalled height word changed");

endmodule

bind terrain_value_noise_height_core tvnh_checker u_tvnh_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .coord_stall  (coord_stall),
    .height_valid (height_valid),
    .height_stall (height_stall),
    .height       (height)
);
